### hdl/lzsd_pkg.sv
// ---------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants of the LZSS stream decompressor.
// ---------------------------------------------------------------------------
package lzsd_pkg;

   localparam int HIST_DEPTH     = 4096;
   localparam int ADDR_W         = 12;
   localparam int LIMIT_W        = 24;
   localparam int LEN_W          = 5;
   localparam int ITEMS_W        = 4;
   localparam logic [LEN_W-1:0]   LEN_BIAS       = 5'd3;
   localparam logic [ITEMS_W-1:0] ITEMS_PER_FLAG = 4'd8;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 24'hFFFFFF;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               byte_valid;
      logic               stream_done;
      logic [LIMIT_W-1:0] produced_count;
      logic               run_last;
   } rsp_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] out_limit;
   } csr_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic load_flags;
      logic shift_flags;
      logic hold_first;
      logic start_copy;
      logic rd_issue;
      logic emit_lit;
      logic emit_copy;
      logic emit_done;
      logic run_last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic flag_msb;
      logic at_limit;
      logic at_limit_next;
      logic off_zero;
      logic len_zero;
      logic len_one;
      logic rsp_free;
   } sts_type;

endpackage

### hdl/lzsd_stream_if.sv
// ---------------------------------------------------------------------------
// lzsd_stream_if
// Valid/ready channel carrying one payload struct per transaction.
// ---------------------------------------------------------------------------
interface lzsd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hdl/lzsd_ram.sv
// ---------------------------------------------------------------------------
// lzsd_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module lzsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/lzsd_datapath.sv
// ---------------------------------------------------------------------------
// lzsd_datapath
// History memory, byte counter, token registers, limit and result register.
// ---------------------------------------------------------------------------
module lzsd_datapath #(
   parameter int COUNT_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lzsd_pkg::req_type      req_data,
   input  lzsd_pkg::cmd_type      cmd,
   output lzsd_pkg::sts_type      sts,
   lzsd_stream_if.source          rsp_bus,
   lzsd_stream_if.sink            csr_bus
);
   localparam int CMP_W = ((COUNT_BITS > lzsd_pkg::LIMIT_W) ? COUNT_BITS
                                                            : lzsd_pkg::LIMIT_W) + 1;

   logic [lzsd_pkg::LIMIT_W-1:0] limit_ff;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic [7:0]                   flags_ff, held_ff, byte_ff;
   logic [lzsd_pkg::ADDR_W-1:0]  off_ff;
   logic [lzsd_pkg::LEN_W-1:0]   len_ff;
   logic                         src_ok_ff;
   logic                         rsp_valid_ff;
   lzsd_pkg::rsp_type            rsp_data_ff;

   logic [lzsd_pkg::ADDR_W-1:0]  new_off;
   logic [lzsd_pkg::ADDR_W-1:0]  rd_addr;
   logic [7:0]                   ram_q, copy_byte, emit_byte;
   logic                         ram_we;
   logic [CMP_W-1:0]             count_x, limit_x, next_x;

   assign count_in = count_ff + 1'b1;
   assign new_off  = {held_ff[3:0], req_data.in_byte};
   assign rd_addr  = count_ff[lzsd_pkg::ADDR_W-1:0] - off_ff;
   assign count_x  = CMP_W'(count_ff);
   assign limit_x  = CMP_W'(limit_ff);
   assign next_x   = CMP_W'(count_in);

   assign copy_byte = src_ok_ff ? ram_q : 8'h00;
   assign emit_byte = cmd.emit_copy ? copy_byte : byte_ff;
   assign ram_we    = cmd.emit_lit | cmd.emit_copy;

   always_comb begin
      sts.flag_msb      = flags_ff[7];
      sts.at_limit      = (count_x >= limit_x) || (count_ff == '1);
      sts.at_limit_next = (next_x >= limit_x) ||
                          (count_ff == {{(COUNT_BITS-1){1'b1}}, 1'b0});
      sts.off_zero      = (new_off == '0);
      sts.len_zero      = (len_ff == '0);
      sts.len_one       = (len_ff == lzsd_pkg::LEN_W'(1));
      sts.rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   end

   lzsd_ram #(
      .WIDTH (8),
      .DEPTH (lzsd_pkg::HIST_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[lzsd_pkg::ADDR_W-1:0]),
      .wr_data (emit_byte),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= lzsd_pkg::LIMIT_RESET;
         count_ff     <= '0;
         flags_ff     <= '0;
         held_ff      <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            limit_ff <= csr_bus.data.out_limit;
         end
         if (cmd.load_flags) begin
            flags_ff <= req_data.in_byte;
         end else if (cmd.shift_flags) begin
            flags_ff <= {flags_ff[6:0], 1'b0};
         end
         if (cmd.hold_first) begin
            held_ff <= req_data.in_byte;
         end
         if (cmd.start_copy) begin
            len_ff <= lzsd_pkg::LEN_W'(held_ff[7:4]) + lzsd_pkg::LEN_BIAS;
         end else if (cmd.emit_copy) begin
            len_ff <= len_ff - 1'b1;
         end
         if (ram_we) begin
            count_ff <= count_in;
         end
         if (ram_we || cmd.emit_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_ff <= req_data.in_byte;
      end
      if (cmd.start_copy) begin
         off_ff <= new_off;
      end
      if (cmd.rd_issue) begin
         src_ok_ff <= (COUNT_BITS'(off_ff) <= count_ff);
      end
      if (ram_we) begin
         rsp_data_ff.out_byte       <= emit_byte;
         rsp_data_ff.byte_valid     <= 1'b1;
         rsp_data_ff.stream_done    <= 1'b0;
         rsp_data_ff.produced_count <= lzsd_pkg::LIMIT_W'(count_in);
         rsp_data_ff.run_last       <= cmd.run_last;
      end else if (cmd.emit_done) begin
         rsp_data_ff.out_byte       <= 8'h00;
         rsp_data_ff.byte_valid     <= 1'b0;
         rsp_data_ff.stream_done    <= 1'b1;
         rsp_data_ff.produced_count <= lzsd_pkg::LIMIT_W'(count_ff);
         rsp_data_ff.run_last       <= 1'b1;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;
   assign csr_bus.ready = 1'b1;
endmodule

### hdl/lzsd_ctrl.sv
// ---------------------------------------------------------------------------
// lzsd_ctrl
// Parser and copy sequencer: flag tracking, token assembly, result ordering.
// ---------------------------------------------------------------------------
module lzsd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last,
   output logic              req_ready,
   input  lzsd_pkg::sts_type sts,
   output lzsd_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_LIT,
      S_COPY_RD,
      S_COPY_WR,
      S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic [lzsd_pkg::ITEMS_W-1:0]  items_ff, items_in;
   logic                          await_ff, await_in;
   logic                          finished_ff, finished_in;
   logic                          last_ff, last_in;
   logic                          accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      items_in    = items_ff;
      await_in    = await_ff;
      finished_in = finished_ff;
      last_in     = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               last_in     = req_last;
               if (!finished_ff) begin
                  if (items_ff == '0) begin
                     cmd.load_flags = 1'b1;
                     items_in       = lzsd_pkg::ITEMS_PER_FLAG;
                     state_in       = req_last ? S_DONE : S_IDLE;
                  end else if (sts.flag_msb) begin
                     state_in = sts.at_limit ? S_DONE : S_LIT;
                  end else if (!await_ff) begin
                     cmd.hold_first = 1'b1;
                     await_in       = 1'b1;
                     state_in       = req_last ? S_DONE : S_IDLE;
                  end else begin
                     await_in = 1'b0;
                     if (sts.off_zero) begin
                        state_in = S_DONE;
                     end else begin
                        cmd.start_copy  = 1'b1;
                        cmd.shift_flags = 1'b1;
                        items_in        = items_ff - 1'b1;
                        state_in        = S_COPY_RD;
                     end
                  end
               end
            end
         end
         S_LIT: begin
            if (sts.rsp_free) begin
               cmd.emit_lit    = 1'b1;
               cmd.run_last    = !last_ff;
               cmd.shift_flags = 1'b1;
               items_in        = items_ff - 1'b1;
               state_in        = last_ff ? S_DONE : S_IDLE;
            end
         end
         S_COPY_RD: begin
            if (sts.len_zero || sts.at_limit) begin
               state_in = last_ff ? S_DONE : S_IDLE;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_COPY_WR;
            end
         end
         S_COPY_WR: begin
            if (sts.rsp_free) begin
               cmd.emit_copy = 1'b1;
               cmd.run_last  = (sts.len_one || sts.at_limit_next) && !last_ff;
               state_in      = S_COPY_RD;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.emit_done = 1'b1;
               finished_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         items_ff    <= '0;
         await_ff    <= 1'b0;
         finished_ff <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         items_ff    <= items_in;
         await_ff    <= await_in;
         finished_ff <= finished_in;
         last_ff     <= last_in;
      end
   end

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_lit || cmd.emit_copy || cmd.emit_done) |-> sts.rsp_free)
      else $error("result loaded while output register is occupied");

   a_copy_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY_WR) |-> ($past(state_ff) == S_COPY_RD ||
                                   $past(state_ff) == S_COPY_WR))
      else $error("copy write stage entered without a history read");

   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !(cmd.emit_lit || cmd.emit_copy || cmd.emit_done))
      else $error("result produced after end of stream");

   a_done_sets_finished: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_done |=> finished_ff)
      else $error("end-of-stream result did not stop decoding");
endmodule

### hdl/lzss_stream_decompressor.sv
// ---------------------------------------------------------------------------
// lzss_stream_decompressor
// LZSS decoder with a 4096-byte history, flag-byte framing and output limit.
// ---------------------------------------------------------------------------
// A flag byte or first token byte is taken in the idle state; a literal
//   goes through the literal state into the result register, waiting while
//   that register is occupied; a done result goes through the done state.
// A copy token yields up to 18 bytes, each a history read, then write and
//   result; the registered history RAM read port keeps read and write apart.
// Reset: synchronous; the block takes input in the first cycle after reset.
//   The history needs no clearing pass: the byte counter marks which entries
//   hold data, and older entries read as zero.
// ---------------------------------------------------------------------------
module lzss_stream_decompressor #(
   parameter int COUNT_BITS = 24
) (
   input  logic          clock,
   input  logic          reset,
   lzsd_stream_if.sink   req_bus,
   lzsd_stream_if.source rsp_bus,
   lzsd_stream_if.sink   csr_bus
);
   lzsd_pkg::cmd_type cmd;
   lzsd_pkg::sts_type sts;
   lzsd_pkg::req_type req_data;
   logic              req_ready;

   // Take the request payload apart: the controller only needs the end mark,
   // the datapath consumes the byte.
   assign req_data      = req_bus.data;
   assign req_bus.ready = req_ready;

   // Controller: flag bits count, token assembly, copy sequencing and the
   // order of byte and done transactions.
   lzsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_data.in_last),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: history RAM, counter, limit register, result register.
   lzsd_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_bus  (rsp_bus),
      .csr_bus  (csr_bus)
   );
endmodule
